@@ design/tfe_pkg.sv @@
// Shared types, constants and the CRC-ITU-T byte update for the TLV frame encoder.
`default_nettype none

package tfe_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEAD_BYTE   = 2'd0,
    REG_CRC_SEED    = 2'd1,
    REG_MAX_PAYLOAD = 2'd2
  } cfg_reg_t;

  localparam logic [7:0]  HEAD_BYTE_RESET   = 8'hFD;
  localparam logic [15:0] CRC_SEED_RESET    = 16'h1E50;
  localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd123;
  localparam logic [7:0]  PAYLOAD_LIMIT     = 8'd250;
  localparam logic [7:0]  FIXED_OVERHEAD    = 8'd5;
  localparam logic [15:0] CRC_POLY          = 16'h1021;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // one accepted payload byte, already classified
  typedef struct packed {
    logic        start;
    logic [15:0] seed;
    logic [7:0]  head;
    logic [7:0]  tag;
    logic [7:0]  len;
    logic [7:0]  data;
    logic        crc;
    logic        mism;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_frame;
    logic       count_mismatch;
  } result_t;

  typedef enum logic [5:0] {
    STEP_HEAD = 6'b000001,
    STEP_TAG  = 6'b000010,
    STEP_LEN  = 6'b000100,
    STEP_DATA = 6'b001000,
    STEP_CRCL = 6'b010000,
    STEP_CRCH = 6'b100000
  } step_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/tlv_frame_encoder_crc16.sv @@
// Top level of the TLV frame encoder with CRC-ITU-T.
`default_nettype none

// One payload byte is taken per transaction and, while the command queue
// has room, one can be pushed every cycle. Each byte becomes a command that
// the back end turns into one to six output bytes (header on the first byte
// of a frame, CRC after the closing byte), at one output byte per cycle while
// the result queue has room, so sustained throughput is set by the back-end
// sequencer: a frame of n sent payload bytes gives n + 5 output bytes.
// Dropped surplus bytes and the closing flag after the CRC give no output.
// Configuration is sampled at the first byte of each frame.
module tlv_frame_encoder_crc16 (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_write,
  input  wire [tfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire [tfe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire                              push,
  output logic                             full,
  input  wire [7:0]                        tag_value,
  input  wire [7:0]                        payload_count,
  input  wire [7:0]                        data_byte,
  input  wire                              final_payload_byte,
  output logic                             empty,
  input  wire                              pop,
  output logic [7:0]                       out_byte,
  output logic                             end_of_run,
  output logic                             end_of_frame,
  output logic                             count_mismatch
);

  logic          cmd_valid;
  logic          cmd_pop;
  tfe_pkg::cmd_t cmd;

  tfe_front u_front (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .push               (push),
    .full               (full),
    .tag_value          (tag_value),
    .payload_count      (payload_count),
    .data_byte          (data_byte),
    .final_payload_byte (final_payload_byte),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_pop            (cmd_pop)
  );

  tfe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .end_of_run     (end_of_run),
    .end_of_frame   (end_of_frame),
    .count_mismatch (count_mismatch)
  );

endmodule

`default_nettype wire

@@ design/tfe_front.sv @@
// Front end: configuration registers, frame tracking and the command queue.
`default_nettype none

module tfe_front (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write,
  input  wire  [tfe_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [tfe_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire                                  push,
  output logic                                 full,
  input  wire  [7:0]                           tag_value,
  input  wire  [7:0]                           payload_count,
  input  wire  [7:0]                           data_byte,
  input  wire                                  final_payload_byte,
  output logic                                 cmd_valid,
  output tfe_pkg::cmd_t                        cmd,
  input  wire                                  cmd_pop
);

  logic [7:0]  head_byte;
  logic [15:0] crc_seed;
  logic [7:0]  max_payload;

  logic       in_frame;
  logic [7:0] bytes_sent;
  logic [7:0] clipped_length;
  logic       crc_done;

  logic [7:0] limit;
  logic [7:0] new_clip;
  logic [7:0] cur_clip;
  logic [7:0] cur_sent;
  logic       cur_done;
  logic [7:0] sent_inc;
  logic       hit;
  logic       accept;
  logic       cmd_push;
  tfe_pkg::cmd_t cmd_new;

  tfe_pkg::cmd_t                  cmd_mem [tfe_pkg::CMD_DEPTH];
  logic [tfe_pkg::CMD_PTR_W-1:0]  wr_ptr;
  logic [tfe_pkg::CMD_PTR_W-1:0]  rd_ptr;
  logic [tfe_pkg::CMD_CNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte   <= tfe_pkg::HEAD_BYTE_RESET;
      crc_seed    <= tfe_pkg::CRC_SEED_RESET;
      max_payload <= tfe_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      case (tfe_pkg::cfg_reg_t'(cfg_index))
        tfe_pkg::REG_HEAD_BYTE:   head_byte   <= cfg_data[7:0];
        tfe_pkg::REG_CRC_SEED:    crc_seed    <= cfg_data;
        tfe_pkg::REG_MAX_PAYLOAD: max_payload <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (max_payload > tfe_pkg::PAYLOAD_LIMIT) begin
      limit = tfe_pkg::PAYLOAD_LIMIT;
    end else if (max_payload == 8'd0) begin
      limit = 8'd1;
    end else begin
      limit = max_payload;
    end
    if (payload_count > limit) begin
      new_clip = limit;
    end else if (payload_count == 8'd0) begin
      new_clip = 8'd1;
    end else begin
      new_clip = payload_count;
    end
    cur_clip = in_frame ? clipped_length : new_clip;
    cur_sent = in_frame ? bytes_sent : 8'd0;
    cur_done = in_frame & crc_done;
    sent_inc = cur_sent + 8'd1;
    hit      = sent_inc >= cur_clip;

    cmd_new.start = ~in_frame;
    cmd_new.seed  = crc_seed;
    cmd_new.head  = head_byte;
    cmd_new.tag   = tag_value;
    cmd_new.len   = cur_clip + tfe_pkg::FIXED_OVERHEAD;
    cmd_new.data  = data_byte;
    cmd_new.crc   = hit | final_payload_byte;
    cmd_new.mism  = ~hit & final_payload_byte;
  end

  assign full      = count == tfe_pkg::CMD_CNT_W'(tfe_pkg::CMD_DEPTH);
  assign cmd_valid = count != '0;
  assign accept    = push & ~full;
  assign cmd_push  = accept & ~cur_done;
  assign cmd       = cmd_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      bytes_sent     <= '0;
      clipped_length <= '0;
      crc_done       <= 1'b0;
    end else if (accept) begin
      in_frame       <= ~final_payload_byte;
      clipped_length <= cur_clip;
      if (!cur_done) begin
        bytes_sent <= sent_inc;
        crc_done   <= hit | final_payload_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_push) begin
      cmd_mem[wr_ptr] <= cmd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (cmd_push) begin
        wr_ptr <= wr_ptr + tfe_pkg::CMD_PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + tfe_pkg::CMD_PTR_W'(1);
      end
      case ({cmd_push, cmd_pop})
        2'b10:   count <= count + tfe_pkg::CMD_CNT_W'(1);
        2'b01:   count <= count - tfe_pkg::CMD_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/tfe_back.sv @@
// Back end: byte sequencer, running CRC and the result queue.
`default_nettype none

module tfe_back (
  input  wire            clk,
  input  wire            rst,
  input  wire            cmd_valid,
  input  tfe_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           empty,
  input  wire            pop,
  output logic [7:0]     out_byte,
  output logic           end_of_run,
  output logic           end_of_frame,
  output logic           count_mismatch
);

  logic                 busy;
  tfe_pkg::step_t       step;
  tfe_pkg::step_t       eff_step;
  tfe_pkg::step_t       step_next;
  logic [15:0]          crc;
  logic [15:0]          crc_next;
  logic                 is_final;
  logic                 emit;
  logic                 oq_full;
  logic                 oq_pop;
  tfe_pkg::result_t     res;

  tfe_pkg::result_t              oq_mem [tfe_pkg::OQ_DEPTH];
  logic [tfe_pkg::OQ_PTR_W-1:0]  oq_wr;
  logic [tfe_pkg::OQ_PTR_W-1:0]  oq_rd;
  logic [tfe_pkg::OQ_CNT_W-1:0]  oq_count;

  assign oq_full = oq_count == tfe_pkg::OQ_CNT_W'(tfe_pkg::OQ_DEPTH);
  assign empty   = oq_count == '0;
  assign oq_pop  = pop & ~empty;
  assign emit    = cmd_valid & ~oq_full;

  always_comb begin
    if (busy) begin
      eff_step = step;
    end else begin
      eff_step = cmd.start ? tfe_pkg::STEP_HEAD : tfe_pkg::STEP_DATA;
    end
    is_final  = (eff_step == tfe_pkg::STEP_CRCH) ||
                ((eff_step == tfe_pkg::STEP_DATA) && !cmd.crc);
    crc_next  = crc;
    step_next = eff_step;
    res.end_of_frame   = 1'b0;
    res.count_mismatch = 1'b0;
    case (eff_step)
      tfe_pkg::STEP_HEAD: begin
        res.out_byte = cmd.head;
        crc_next     = tfe_pkg::crc_feed(cmd.seed, cmd.head);
        step_next    = tfe_pkg::STEP_TAG;
      end
      tfe_pkg::STEP_TAG: begin
        res.out_byte = cmd.tag;
        crc_next     = tfe_pkg::crc_feed(crc, cmd.tag);
        step_next    = tfe_pkg::STEP_LEN;
      end
      tfe_pkg::STEP_LEN: begin
        res.out_byte = cmd.len;
        crc_next     = tfe_pkg::crc_feed(crc, cmd.len);
        step_next    = tfe_pkg::STEP_DATA;
      end
      tfe_pkg::STEP_DATA: begin
        res.out_byte = cmd.data;
        crc_next     = tfe_pkg::crc_feed(crc, cmd.data);
        step_next    = tfe_pkg::STEP_CRCL;
      end
      tfe_pkg::STEP_CRCL: begin
        res.out_byte       = crc[7:0];
        res.count_mismatch = cmd.mism;
        step_next          = tfe_pkg::STEP_CRCH;
      end
      tfe_pkg::STEP_CRCH: begin
        res.out_byte       = crc[15:8];
        res.end_of_frame   = 1'b1;
        res.count_mismatch = cmd.mism;
      end
      default: begin
        res.out_byte = 8'h00;
      end
    endcase
    res.end_of_run = is_final;
  end

  assign cmd_pop = emit & is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= tfe_pkg::STEP_HEAD;
    end else if (emit) begin
      busy <= ~is_final;
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      crc <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_mem[oq_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (emit) begin
        oq_wr <= oq_wr + tfe_pkg::OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + tfe_pkg::OQ_PTR_W'(1);
      end
      case ({emit, oq_pop})
        2'b10:   oq_count <= oq_count + tfe_pkg::OQ_CNT_W'(1);
        2'b01:   oq_count <= oq_count - tfe_pkg::OQ_CNT_W'(1);
        default: oq_count <= oq_count;
      endcase
    end
  end

  assign out_byte       = oq_mem[oq_rd].out_byte;
  assign end_of_run     = oq_mem[oq_rd].end_of_run;
  assign end_of_frame   = oq_mem[oq_rd].end_of_frame;
  assign count_mismatch = oq_mem[oq_rd].count_mismatch;

  a_busy_has_cmd: assert property (@(posedge clk) disable iff (rst)
    busy |-> cmd_valid)
    else $error("sequencer mid-transaction without a command");

  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    oq_count <= tfe_pkg::OQ_CNT_W'(tfe_pkg::OQ_DEPTH))
    else $error("result queue overfilled");

  a_eof_ends_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_frame) |-> end_of_run)
    else $error("frame closed on a result that is not last of its run");

  a_crcl_then_crch: assert property (@(posedge clk) disable iff (rst)
    (emit && eff_step == tfe_pkg::STEP_CRCL) |=> (busy && step == tfe_pkg::STEP_CRCH))
    else $error("CRC low byte not followed by CRC high byte");

endmodule

`default_nettype wire
